// ===== hdl/hex_dump_line_formatter_top_macros.svh =====
// Assertion macros used by the checker.
`ifndef HEX_DUMP_LINE_FORMATTER_TOP_MACROS_SVH
`define HEX_DUMP_LINE_FORMATTER_TOP_MACROS_SVH

// Same-cycle implication.
`define HDLF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hdlf assertion failed");

// Next-cycle implication.
`define HDLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hdlf assertion failed");

`endif

// ===== hdl/hdlf_pkg.sv =====
package hdlf_pkg;

  // Largest supported offset width in decimal digits.
  localparam int unsigned MaxDigits = 12;
  localparam int unsigned DigitIdxW = 4;

  localparam logic [7:0] CharNewline = 8'h0a;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharLowerA  = 8'h61;

  typedef logic [3:0] bcd_t;

  // One queued request: the byte, whether a line header precedes it,
  // and the offset snapshot in BCD (digit 0 is least significant).
  typedef struct packed {
    logic [7:0]                 data_byte;
    logic                       header;
    logic [MaxDigits*4-1:0]     offset;
  } item_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CharZero + {4'h0, nib};
    end else begin
      r = CharLowerA + {4'h0, nib - 4'd10};
    end
    return r;
  endfunction

  function automatic logic [7:0] dec_char(input bcd_t d);
    return CharZero + {4'h0, d};
  endfunction

endpackage

// ===== hdl/hdlf_if.sv =====
interface hdlf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_file;

  modport source (output valid, output data_byte, output first_of_file, input ready);
  modport sink   (input valid, input data_byte, input first_of_file, output ready);
endinterface

interface hdlf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// ===== hdl/hdlf_front.sv =====
module hdlf_front #(
  parameter int unsigned BYTES_PER_LINE = 20,
  parameter int unsigned OFFSET_DIGITS  = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hdlf_in_if.sink       in_i,
  input  logic          full_i,
  output logic          push_o,
  output hdlf_pkg::item_t item_o
);

  localparam int unsigned ColW = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;
  localparam logic [ColW-1:0] ColLast = ColW'(BYTES_PER_LINE - 1);

  logic [ColW-1:0]   col_q, col_d, col_base;
  hdlf_pkg::bcd_t    dig_q [OFFSET_DIGITS];
  hdlf_pkg::bcd_t    dig_d [OFFSET_DIGITS];
  hdlf_pkg::bcd_t    dig_base [OFFSET_DIGITS];

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    logic carry;
    col_base = in_i.first_of_file ? '0 : col_q;
    col_d    = (col_base == ColLast) ? '0 : col_base + 1'b1;
    carry    = 1'b1;
    for (int i = 0; i < OFFSET_DIGITS; i++) begin
      dig_base[i] = in_i.first_of_file ? 4'd0 : dig_q[i];
      if (carry && dig_base[i] == 4'd9) begin
        dig_d[i] = 4'd0;
      end else begin
        dig_d[i] = dig_base[i] + {3'b000, carry};
        carry    = 1'b0;
      end
    end
  end

  always_comb begin
    item_o           = '0;
    item_o.data_byte = in_i.data_byte;
    item_o.header    = (col_base == '0);
    for (int i = 0; i < OFFSET_DIGITS; i++) begin
      item_o.offset[i*4 +: 4] = dig_base[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      for (int i = 0; i < OFFSET_DIGITS; i++) begin
        dig_q[i] <= 4'd0;
      end
    end else if (push_o) begin
      col_q <= col_d;
      for (int i = 0; i < OFFSET_DIGITS; i++) begin
        dig_q[i] <= dig_d[i];
      end
    end
  end

endmodule

// ===== hdl/hdlf_fifo.sv =====
module hdlf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hdlf_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output hdlf_pkg::item_t item_o
);

  localparam int unsigned Depth = 2;

  hdlf_pkg::item_t mem_q [Depth];
  logic            wr_q, wr_d;
  logic            rd_q, rd_d;
  logic [1:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'(Depth));
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i  ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== hdl/hdlf_back.sv =====
module hdlf_back #(
  parameter int unsigned OFFSET_DIGITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  hdlf_pkg::item_t item_i,
  output logic            pop_o,
  hdlf_out_if.source      out_o
);

  localparam int unsigned StepW = $clog2(OFFSET_DIGITS + 4);
  localparam logic [StepW-1:0] StepSpace = StepW'(OFFSET_DIGITS + 1);
  localparam logic [StepW-1:0] StepHi    = StepW'(OFFSET_DIGITS + 2);
  localparam logic [StepW-1:0] StepLo    = StepW'(OFFSET_DIGITS + 3);

  logic                         active_q, active_d;
  logic [StepW-1:0]             step_q, step_d, cur_step;
  logic                         emit;
  logic                         out_valid_q, out_valid_d;
  logic [7:0]                   text_q, text_d;
  logic                         last_q, last_d;
  logic [hdlf_pkg::DigitIdxW-1:0] sel;
  hdlf_pkg::bcd_t               digit;

  assign cur_step = active_q ? step_q : (item_i.header ? '0 : StepSpace);
  assign emit     = valid_i && (!out_valid_q || out_o.ready);
  assign pop_o    = emit && (cur_step == StepLo);

  assign sel   = hdlf_pkg::DigitIdxW'(OFFSET_DIGITS - 32'(cur_step));
  assign digit = item_i.offset[sel*4 +: 4];

  always_comb begin
    last_d = 1'b0;
    if (cur_step == '0) begin
      text_d = hdlf_pkg::CharNewline;
    end else if (cur_step == StepSpace) begin
      text_d = hdlf_pkg::CharSpace;
    end else if (cur_step == StepHi) begin
      text_d = hdlf_pkg::hex_char(item_i.data_byte[7:4]);
    end else if (cur_step == StepLo) begin
      text_d = hdlf_pkg::hex_char(item_i.data_byte[3:0]);
      last_d = 1'b1;
    end else begin
      text_d = hdlf_pkg::dec_char(digit);
    end
  end

  always_comb begin
    active_d    = active_q;
    step_d      = step_q;
    out_valid_d = out_o.ready ? 1'b0 : out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (cur_step == StepLo) begin
        active_d = 1'b0;
      end else begin
        active_d = 1'b1;
        step_d   = cur_step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      text_q <= text_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.text_char = text_q;
  assign out_o.last_char = last_q;

endmodule

// ===== hdl/hex_dump_line_formatter_top.sv =====
// Hex dump line formatter.
// in_i  : one request per data byte (data_byte, first_of_file), valid/ready.
// out_o : one ASCII character per transfer (text_char, last_char), valid/ready.
// Each byte yields " hh" (3 characters); a byte that starts a line, every
// BYTES_PER_LINE bytes or on first_of_file, is preceded by a newline and the
// byte offset as OFFSET_DIGITS zero-padded decimal digits (4 + OFFSET_DIGITS
// characters in all). last_char marks the low hex digit.
// The front stage counts the line column and the BCD offset and queues each
// request in a two-entry queue; the back stage emits one character per
// cycle from the queue head into a registered output unless the receiver stalls it.
// A request is written into the queue, and its first character is then
// registered into the output before it is valid on out_o.
// The single character output sets the pace: each byte takes 3 or
// 4 + OFFSET_DIGITS characters, about 3.45 on average at the defaults.
// in_i.ready drops only when the queue is full. When the receiver stalls the
// output character holds and the queue fills, then in_i stalls.
// Reset clears the offset, the line column, the queue and the output valid.
module hex_dump_line_formatter_top #(
  parameter int unsigned BYTES_PER_LINE = 20,
  parameter int unsigned OFFSET_DIGITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hdlf_in_if.sink     in_i,
  hdlf_out_if.source  out_o
);

  logic            push, full, pop, head_valid;
  hdlf_pkg::item_t push_item, head_item;

  hdlf_front #(
    .BYTES_PER_LINE (BYTES_PER_LINE),
    .OFFSET_DIGITS  (OFFSET_DIGITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  hdlf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  hdlf_back #(
    .OFFSET_DIGITS (OFFSET_DIGITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .item_i  (head_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== hdl/hdlf_checker.sv =====
`include "hex_dump_line_formatter_top_macros.svh"

module hdlf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_text_i,
  input logic       out_last_i
);

  logic is_hex;
  assign is_hex = (out_text_i >= 8'h30 && out_text_i <= 8'h39) ||
                  (out_text_i >= 8'h61 && out_text_i <= 8'h66);

  // stalled character holds
  `HDLF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_text_i) && $stable(out_last_i))
  // the closing character of a request is a hex digit
  `HDLF_ASSERT_NOW(a_last_is_hex, clk_i, rst_ni, out_valid_i && out_last_i, is_hex)
  // the space is always followed at once by the high digit
  `HDLF_ASSERT_NEXT(a_space_then_digit, clk_i, rst_ni, out_valid_i && out_ready_i && out_text_i == hdlf_pkg::CharSpace, out_valid_i && !out_last_i && is_hex)

endmodule

bind hex_dump_line_formatter_top hdlf_checker u_hdlf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_text_i  (out_o.text_char),
  .out_last_i  (out_o.last_char)
);
